// ===== sv/mvws_pkg.sv =====
package mvws_pkg;

    // default build values
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MV_BITS    = 13;
    localparam int DEF_FRAC_BITS  = 4;

    // configuration register widths and indexes
    localparam int CFG_W_BITS    = 7;
    localparam int CFG_H_BITS    = 9;
    localparam int CFG_MD_BITS   = 4;
    localparam int CFG_DATA_BITS = 9;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_FIELD_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FIELD_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_DIFF     = 2'd2;

    localparam logic [CFG_W_BITS-1:0]  RST_FIELD_WIDTH  = 7'd64;
    localparam logic [CFG_H_BITS-1:0]  RST_FIELD_HEIGHT = 9'd2;
    localparam logic [CFG_MD_BITS-1:0] RST_MAX_DIFF     = 4'd1;

    // job queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    // 3x3 window walk: centre first, then the eight neighbours
    localparam int NUM_TAPS = 9;
    localparam int TAP_BITS = 4;
    localparam logic [TAP_BITS-1:0] LAST_TAP = 4'd8;

    localparam logic [1:0] DIR_ZERO = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    localparam logic [1:0] TAP_DR [NUM_TAPS] = '{
        DIR_ZERO, DIR_NEG, DIR_NEG, DIR_NEG, DIR_ZERO, DIR_ZERO, DIR_POS, DIR_POS, DIR_POS
    };
    localparam logic [1:0] TAP_DC [NUM_TAPS] = '{
        DIR_ZERO, DIR_NEG, DIR_ZERO, DIR_POS, DIR_NEG, DIR_POS, DIR_NEG, DIR_ZERO, DIR_POS
    };

    // weight total of centre alone, and the largest total
    localparam logic [4:0] CENTRE_WEIGHT = 5'd4;
    localparam logic [4:0] MAX_WEIGHT    = 5'd16;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TAP,
        B_LAST,
        B_LOAD,
        B_DIV,
        B_OUT
    } t_bstate;

endpackage

// ===== sv/mvws_queue.sv =====
module mvws_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          s_push;
    logic          s_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) r_wp <= r_wp + 1'b1;
            if (s_pop)  r_rp <= r_rp + 1'b1;
            if (s_push && !s_pop)      r_cnt <= r_cnt + 1'b1;
            else if (s_pop && !s_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (s_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== sv/mvws_front.sv =====
module mvws_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 256,
    parameter int MV_BITS    = 13,
    parameter int AW         = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_h,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [MV_BITS-1:0]                  i_mv_x,
    input  logic [MV_BITS-1:0]                  i_mv_y,
    input  logic                                i_inlier,
    output logic                                o_mem_we,
    output logic [AW-1:0]                       o_mem_waddr,
    output logic [2*MV_BITS:0]                  o_mem_wdata,
    output logic                                o_push,
    output logic [AW+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH):0] o_job,
    input  logic                                i_q_full
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [CW-1:0] r_ic;
    logic [CW-1:0] r_oc;
    logic [HB-1:0] r_row;
    logic [WB-1:0] r_col;
    logic [AW-1:0] r_wa;
    logic [AW-1:0] r_oa;

    logic [CW-1:0] s_total;
    logic          s_acc;
    logic          s_fill;
    logic          s_due;
    logic          s_last;

    assign o_ready = !i_q_full;
    assign s_acc   = i_valid && o_ready;
    assign s_total = CW'(i_w) * CW'(i_h);
    assign s_fill  = (r_ic < s_total);
    assign s_last  = ({1'b0, r_oc} + 1'b1 >= {1'b0, s_total});

    // an output is due once the window below the oldest vector is in, or on any item once the field is in
    always_comb begin
        s_due = 1'b0;
        if (s_acc) begin
            if (s_fill) begin
                s_due = !i_cmd &&
                    ({1'b0, r_ic} + 1'b1 >= {1'b0, r_oc} + (CW+1)'(i_w) + (CW+1)'(2));
            end else begin
                s_due = 1'b1;
            end
        end
    end

    assign o_mem_we    = s_acc && s_fill && !i_cmd;
    assign o_mem_waddr = r_wa;
    assign o_mem_wdata = {i_inlier, i_mv_y, i_mv_x};
    assign o_push      = s_due;
    assign o_job       = {s_last, r_col, r_row, r_oa};

    // store addresses run on across fields so a new field never
    // overwrites the window of a result still in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_wa <= '0;
            r_oa <= '0;
        end else begin
            if (o_mem_we) r_wa <= r_wa + 1'b1;
            if (s_due)    r_oa <= r_oa + 1'b1;
        end
    end

    // field position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ic  <= '0;
            r_oc  <= '0;
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (o_mem_we) r_ic <= r_ic + 1'b1;
            if (s_due) begin
                if (s_last) begin
                    r_ic  <= '0;
                    r_oc  <= '0;
                    r_row <= '0;
                    r_col <= '0;
                end else begin
                    r_oc <= r_oc + 1'b1;
                    if (WW'(r_col) == i_w - 1'b1) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== sv/mvws_back.sv =====
module mvws_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 256,
    parameter int MV_BITS    = 13,
    parameter int FRAC_BITS  = 4,
    parameter int AW         = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_h,
    input  logic [mvws_pkg::CFG_MD_BITS-1:0]    i_md,
    input  logic                                i_mem_we,
    input  logic [AW-1:0]                       i_mem_waddr,
    input  logic [2*MV_BITS:0]                  i_mem_wdata,
    input  logic                                i_job_valid,
    input  logic [AW+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH):0] i_job,
    output logic                                o_job_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [MV_BITS+FRAC_BITS-1:0]        o_fx,
    output logic [MV_BITS+FRAC_BITS-1:0]        o_fy,
    output logic                                o_last
);
    import mvws_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int HB    = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH);
    localparam int EW    = 2 * MV_BITS + 1;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = MV_BITS + 5;
    localparam int DW    = SW + FRAC_BITS;
    localparam int OB    = MV_BITS + FRAC_BITS;
    localparam int DCW   = $clog2(DW + 1);
    localparam int REMW  = 6;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd;

    t_bstate r_state;
    t_bstate n_state;

    logic [AW-1:0]       r_q;
    logic [HB-1:0]       r_row;
    logic [WB-1:0]       r_col;
    logic                r_last;
    logic [TAP_BITS-1:0] r_tap;
    logic                r_d_vld;
    logic                r_d_ctr;
    logic                r_d_inf;
    logic                r_d_edge;
    logic [MV_BITS-1:0]  r_cx;
    logic [MV_BITS-1:0]  r_cy;
    logic signed [SW-1:0] r_sx;
    logic signed [SW-1:0] r_sy;
    logic [4:0]          r_tot;
    logic [DW-1:0]       r_nx;
    logic [DW-1:0]       r_ny;
    logic                r_negx;
    logic                r_negy;
    logic [REMW-1:0]     r_remx;
    logic [REMW-1:0]     r_remy;
    logic [DCW-1:0]      r_dcnt;
    logic [OB-1:0]       r_fx;
    logic [OB-1:0]       r_fy;

    logic [1:0]          s_dr;
    logic [1:0]          s_dc;
    logic [AW-1:0]       s_rbase;
    logic [AW-1:0]       s_raddr;
    logic                s_inf;
    logic                s_edge;

    // window tap address and frame test
    always_comb begin
        s_dr = TAP_DR[r_tap];
        s_dc = TAP_DC[r_tap];
        unique case (s_dr)
            DIR_NEG: s_rbase = r_q - AW'(i_w);
            DIR_POS: s_rbase = r_q + AW'(i_w);
            default: s_rbase = r_q;
        endcase
        unique case (s_dc)
            DIR_NEG: s_raddr = s_rbase - 1'b1;
            DIR_POS: s_raddr = s_rbase + 1'b1;
            default: s_raddr = s_rbase;
        endcase
        s_inf = (s_dr != DIR_NEG || r_row != '0) &&
                (s_dr != DIR_POS || HW'(r_row) != i_h - 1'b1) &&
                (s_dc != DIR_NEG || r_col != '0) &&
                (s_dc != DIR_POS || WW'(r_col) != i_w - 1'b1);
        s_edge = (s_dr == DIR_ZERO) || (s_dc == DIR_ZERO);
    end

    // vector store: written by the front, read one tap a cycle
    always_ff @(posedge i_clk) begin
        if (i_mem_we) r_mem[i_mem_waddr] <= i_mem_wdata;
        r_rd <= r_mem[s_raddr];
    end

    // neighbour test and weighted terms
    logic signed [MV_BITS-1:0] s_nbx;
    logic signed [MV_BITS-1:0] s_nby;
    logic signed [MV_BITS:0]   s_dx;
    logic signed [MV_BITS:0]   s_dy;
    logic signed [MV_BITS:0]   s_mde;
    logic                      s_take;
    logic signed [SW-1:0]      s_tx;
    logic signed [SW-1:0]      s_ty;

    always_comb begin
        s_nbx  = r_rd[MV_BITS-1:0];
        s_nby  = r_rd[2*MV_BITS-1:MV_BITS];
        s_dx   = {s_nbx[MV_BITS-1], s_nbx} - {r_cx[MV_BITS-1], r_cx};
        s_dy   = {s_nby[MV_BITS-1], s_nby} - {r_cy[MV_BITS-1], r_cy};
        s_mde  = (MV_BITS+1)'(i_md);
        s_take = r_d_inf && r_rd[2*MV_BITS] &&
                 (s_dx <= s_mde) && (s_dx >= -s_mde) &&
                 (s_dy <= s_mde) && (s_dy >= -s_mde);
        s_tx   = r_d_edge ? (SW'(s_nbx) <<< 1) : SW'(s_nbx);
        s_ty   = r_d_edge ? (SW'(s_nby) <<< 1) : SW'(s_nby);
    end

    // restoring divide step, both axes
    logic [REMW-1:0] s_shx;
    logic [REMW-1:0] s_shy;
    logic            s_gex;
    logic            s_gey;
    logic [SW-1:0]   s_magx;
    logic [SW-1:0]   s_magy;

    always_comb begin
        s_shx  = {r_remx[REMW-2:0], r_nx[DW-1]};
        s_shy  = {r_remy[REMW-2:0], r_ny[DW-1]};
        s_gex  = (s_shx >= REMW'(r_tot));
        s_gey  = (s_shy >= REMW'(r_tot));
        s_magx = r_sx[SW-1] ? SW'(-r_sx) : SW'(r_sx);
        s_magy = r_sy[SW-1] ? SW'(-r_sy) : SW'(r_sy);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = B_TAP;
                end
            end
            B_TAP:  if (r_tap == LAST_TAP) n_state = B_LAST;
            B_LAST: n_state = B_LOAD;
            B_LOAD: n_state = B_DIV;
            B_DIV:  if (r_dcnt == DCW'(DW)) n_state = B_OUT;
            B_OUT:  if (i_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // tap data valid flag follows the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else          r_d_vld <= (r_state == B_TAP);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid) begin
            {r_last, r_col, r_row, r_q} <= i_job;
            r_tap <= '0;
        end
        if (r_state == B_TAP) begin
            r_tap    <= r_tap + 1'b1;
            r_d_ctr  <= (r_tap == '0);
            r_d_inf  <= s_inf;
            r_d_edge <= s_edge;
        end
        if (r_d_vld) begin
            if (r_d_ctr) begin
                r_cx  <= s_nbx;
                r_cy  <= s_nby;
                r_sx  <= SW'(s_nbx) <<< 2;
                r_sy  <= SW'(s_nby) <<< 2;
                r_tot <= CENTRE_WEIGHT;
            end else if (s_take) begin
                r_sx  <= r_sx + s_tx;
                r_sy  <= r_sy + s_ty;
                r_tot <= r_tot + (r_d_edge ? 5'd2 : 5'd1);
            end
        end
        if (r_state == B_LOAD) begin
            r_nx   <= DW'(s_magx) << FRAC_BITS;
            r_ny   <= DW'(s_magy) << FRAC_BITS;
            r_negx <= r_sx[SW-1];
            r_negy <= r_sy[SW-1];
            r_remx <= '0;
            r_remy <= '0;
            r_dcnt <= '0;
        end
        if (r_state == B_DIV) begin
            if (r_dcnt == DCW'(DW)) begin
                r_fx <= r_negx ? OB'(-r_nx) : OB'(r_nx);
                r_fy <= r_negy ? OB'(-r_ny) : OB'(r_ny);
            end else begin
                r_remx <= s_gex ? s_shx - REMW'(r_tot) : s_shx;
                r_remy <= s_gey ? s_shy - REMW'(r_tot) : s_shy;
                r_nx   <= {r_nx[DW-2:0], s_gex};
                r_ny   <= {r_ny[DW-2:0], s_gey};
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    assign o_valid = (r_state == B_OUT);
    assign o_fx    = r_fx;
    assign o_fy    = r_fy;
    assign o_last  = r_last;

    a_tap_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TAP && r_tap == LAST_TAP) |=> (r_state == B_LAST))
        else $error("window walk overran its last tap");

    a_tot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_LOAD) |-> (r_tot >= CENTRE_WEIGHT && r_tot <= MAX_WEIGHT))
        else $error("weight total out of range");

    a_tap_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |-> ($past(r_state) == B_TAP))
        else $error("tap data without a tap read");

endmodule

// ===== sv/motion_vector_weighted_smoother_core.sv =====
// motion vector field smoother, 3x3 weighted average per vector
//
// input stream s_axis: one item per vector of the field in raster order;
// tuser = 1 marks a flush tick without data. output stream m_axis: one
// filtered vector per vector of the field, tlast on the last vector of the field.
// configuration: i_cfg_we with i_cfg_addr 0 = field width, 1 = field height
// (either one restarts the field), 2 = max difference; write only when idle.
//
// the result for a vector is issued once the vector width+1 places later
// has arrived; the last width+1 results are drained by further items
// (flush or data) once the whole field is in.
// each result passes through the back end in order: it takes the job from the
// queue, reads the window taps from the single read port of the vector store,
// finishes the last tap, loads and runs the bit-serial divider, then holds the
// result until the receiver takes it. the back end takes no new job before
// then. items that cause no result are taken at one per cycle while the job
// queue has room. a stalled receiver holds the result; the front keeps taking
// items until the job queue is full. reset clears the front's counters and the
// queue, returns the back end to idle, and loads width 64, height 2, max
// difference 1.
module motion_vector_weighted_smoother_core #(
    parameter int MAX_WIDTH  = mvws_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mvws_pkg::DEF_MAX_HEIGHT,
    parameter int MV_BITS    = mvws_pkg::DEF_MV_BITS,
    parameter int FRAC_BITS  = mvws_pkg::DEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // mv_x, mv_y, inlier
    input  logic [((2*MV_BITS+1+7)/8)*8-1:0]       i_s_axis_tdata,
    // cmd
    input  logic                                   i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // filt_x, filt_y
    output logic [((2*(MV_BITS+FRAC_BITS)+7)/8)*8-1:0] o_m_axis_tdata,
    // frame_end
    output logic                                   o_m_axis_tlast,
    input  logic                                   i_cfg_we,
    input  logic [mvws_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [mvws_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import mvws_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int HB  = $clog2(MAX_HEIGHT);
    localparam int WB  = $clog2(MAX_WIDTH);
    localparam int AW  = $clog2(2 * MAX_WIDTH + 4 + 2 * QUEUE_DEPTH);
    localparam int JW  = AW + HB + WB + 1;
    localparam int OB  = MV_BITS + FRAC_BITS;
    localparam int ODW = ((2 * OB + 7) / 8) * 8;

    logic [CFG_W_BITS-1:0]  r_cfg_w;
    logic [CFG_H_BITS-1:0]  r_cfg_h;
    logic [CFG_MD_BITS-1:0] r_cfg_md;
    logic                   s_restart;
    logic [WW-1:0]          s_w;
    logic [HW-1:0]          s_h;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= RST_FIELD_WIDTH;
            r_cfg_h  <= RST_FIELD_HEIGHT;
            r_cfg_md <= RST_MAX_DIFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_FIELD_WIDTH:  r_cfg_w  <= i_cfg_data[CFG_W_BITS-1:0];
                REG_FIELD_HEIGHT: r_cfg_h  <= i_cfg_data[CFG_H_BITS-1:0];
                REG_MAX_DIFF:     r_cfg_md <= i_cfg_data[CFG_MD_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign s_restart = i_cfg_we &&
        (i_cfg_addr == REG_FIELD_WIDTH || i_cfg_addr == REG_FIELD_HEIGHT);

    // saturate field size to the supported range
    always_comb begin
        if (int'(r_cfg_w) < 2)              s_w = WW'(2);
        else if (int'(r_cfg_w) > MAX_WIDTH) s_w = WW'(MAX_WIDTH);
        else                                s_w = WW'(r_cfg_w);
        if (int'(r_cfg_h) < 2)               s_h = HW'(2);
        else if (int'(r_cfg_h) > MAX_HEIGHT) s_h = HW'(MAX_HEIGHT);
        else                                 s_h = HW'(r_cfg_h);
    end

    logic                 s_mem_we;
    logic [AW-1:0]        s_mem_waddr;
    logic [2*MV_BITS:0]   s_mem_wdata;
    logic                 s_push;
    logic [JW-1:0]        s_job_in;
    logic                 s_q_full;
    logic                 s_pop;
    logic                 s_job_valid;
    logic [JW-1:0]        s_job;
    logic [OB-1:0]        s_fx;
    logic [OB-1:0]        s_fy;

    mvws_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MV_BITS   (MV_BITS),
        .AW        (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (s_restart),
        .i_w        (s_w),
        .i_h        (s_h),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_cmd      (i_s_axis_tuser),
        .i_mv_x     (i_s_axis_tdata[MV_BITS-1:0]),
        .i_mv_y     (i_s_axis_tdata[2*MV_BITS-1:MV_BITS]),
        .i_inlier   (i_s_axis_tdata[2*MV_BITS]),
        .o_mem_we   (s_mem_we),
        .o_mem_waddr(s_mem_waddr),
        .o_mem_wdata(s_mem_wdata),
        .o_push     (s_push),
        .o_job      (s_job_in),
        .i_q_full   (s_q_full)
    );

    mvws_queue #(
        .W    (JW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_push),
        .i_data (s_job_in),
        .o_full (s_q_full),
        .i_pop  (s_pop),
        .o_valid(s_job_valid),
        .o_data (s_job)
    );

    mvws_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MV_BITS   (MV_BITS),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_w        (s_w),
        .i_h        (s_h),
        .i_md       (r_cfg_md),
        .i_mem_we   (s_mem_we),
        .i_mem_waddr(s_mem_waddr),
        .i_mem_wdata(s_mem_wdata),
        .i_job_valid(s_job_valid),
        .i_job      (s_job),
        .o_job_pop  (s_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_fx       (s_fx),
        .o_fy       (s_fy),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = ODW'({s_fy, s_fx});

endmodule
